// ===== rtl/core/address_range_symbolizer_defines.svh =====
// assertion macros for the address range symbolizer
`ifndef ADDRESS_RANGE_SYMBOLIZER_DEFINES_SVH
`define ADDRESS_RANGE_SYMBOLIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define ARSYM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("address_range_symbolizer: check failed");

`define ARSYM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address_range_symbolizer: check failed");

`define ARSYM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address_range_symbolizer: check failed");

`else

`define ARSYM_ASSERT_ALWAYS(label, expr)
`define ARSYM_ASSERT_IMPLY(label, ante, cons)
`define ARSYM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/arsym_pkg.sv =====
`default_nettype none

package arsym_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned NEAR_LIMIT  = 4096;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 64;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t FULL_COUNT = cnt_t'(TABLE_DEPTH);

    // register selects, taken from paddr above the 8-byte lane
    localparam logic [1:0] REG_WINDOW_BASE   = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd1;
    localparam logic [1:0] REG_FAULT_ADDRESS = 2'd2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ABS  = 2'd1;
    localparam logic [1:0] KIND_RAW  = 2'd2;

    localparam logic [1:0] HINT_NONE  = 2'd0;
    localparam logic [1:0] HINT_EQUAL = 2'd1;
    localparam logic [1:0] HINT_NEAR  = 2'd2;

    localparam logic READ_RAW     = 1'b0;
    localparam logic READ_REBASED = 1'b1;

    typedef struct packed {
        logic [63:0] window_base;
        logic [32:0] window_size;
        logic [63:0] fault_address;
    } cfg_t;

    // one item travelling down the cell row
    typedef struct packed {
        logic        valid;
        logic        query;
        logic [1:0]  kind;
        logic [31:0] off;
        cnt_t        slot;
        logic [31:0] start;
        logic [31:0] length;
        logic        hit;
        idx_t        idx;
        logic [31:0] rel;
        logic [1:0]  hint;
        logic        reading;
        logic [11:0] distance;
        logic        dropped;
    } token_t;

endpackage

`default_nettype wire

// ===== rtl/core/arsym_cell.sv =====
`default_nettype none

module arsym_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  arsym_pkg::idx_t   cell_index,
    input  arsym_pkg::token_t tok_in,
    output arsym_pkg::token_t tok_out
);

    logic [31:0]       start_reg;
    logic [31:0]       length_reg;
    logic [32:0]       end_sum;
    logic              write_en;
    logic              visible;
    logic              hit;
    arsym_pkg::token_t tok_next;
    arsym_pkg::token_t tok_reg;

    assign write_en = adv && tok_in.valid && !tok_in.query && !tok_in.dropped
                      && (tok_in.slot == arsym_pkg::cnt_t'(cell_index));

    // entry exists only if it was appended before this query
    assign visible = arsym_pkg::cnt_t'(cell_index) < tok_in.slot;
    assign end_sum = {1'b0, start_reg} + {1'b0, length_reg};

    assign hit = tok_in.valid && tok_in.query && (tok_in.kind != arsym_pkg::KIND_NONE)
                 && visible && (start_reg <= tok_in.off) && ({1'b0, tok_in.off} < end_sum);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = cell_index;
            tok_next.rel = tok_in.off - start_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            start_reg  <= tok_in.start;
            length_reg <= tok_in.length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/arsym_head.sv =====
`default_nettype none

module arsym_head (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic              cmd,
    input  logic [31:0]       range_start,
    input  logic [31:0]       range_length,
    input  logic [63:0]       query_value,
    input  arsym_pkg::cfg_t   cfg,
    output arsym_pkg::token_t tok,
    output arsym_pkg::cnt_t   count
);

    typedef struct packed {
        logic            valid;
        logic            query;
        logic [1:0]      kind;
        logic [31:0]     off;
        arsym_pkg::cnt_t slot;
        logic [31:0]     start;
        logic [31:0]     length;
        logic            dropped;
        logic [63:0]     value;
        logic [63:0]     rebased;
    } stage_t;

    typedef struct packed {
        logic        eq;
        logic        near;
        logic [11:0] distance;
    } near_t;

    function automatic near_t check_near(input logic [63:0] cand, input logic [63:0] fault);
        logic [64:0] diff;
        near_t       res;
        diff         = {1'b0, fault} - {1'b0, cand};
        res.eq       = (cand != '0) && !diff[64] && (diff[63:0] == '0);
        res.near     = (cand != '0) && !diff[64] && (diff[63:0] != '0)
                       && (diff[63:0] < 64'(arsym_pkg::NEAR_LIMIT));
        res.distance = diff[11:0];
        return res;
    endfunction

    logic              accept;
    logic              is_query;
    logic              full;
    logic [64:0]       base_diff;
    logic              is_abs;
    logic              is_raw;
    stage_t            s1_next;
    stage_t            s1_reg;
    arsym_pkg::cnt_t   count_reg;
    arsym_pkg::cnt_t   count_next;
    near_t             raw_chk;
    near_t             reb_chk;
    logic              fault_on;
    arsym_pkg::token_t tok_next;
    arsym_pkg::token_t tok_reg;

    assign accept   = in_valid && adv;
    assign is_query = (cmd == arsym_pkg::CMD_QUERY);
    assign full     = (count_reg == arsym_pkg::FULL_COUNT);

    // stage 1: window classification and rebased reading
    assign base_diff = {1'b0, query_value} - {1'b0, cfg.window_base};
    assign is_abs = (cfg.window_base != '0) && !base_diff[64]
                    && (base_diff[63:0] < {31'b0, cfg.window_size});
    assign is_raw = (query_value != '0) && (query_value < {31'b0, cfg.window_size});

    always_comb
    begin
        s1_next         = '0;
        s1_next.valid   = accept;
        s1_next.query   = is_query;
        s1_next.slot    = count_reg;
        s1_next.start   = range_start;
        s1_next.length  = range_length;
        s1_next.dropped = !is_query && full;
        s1_next.value   = query_value;
        s1_next.rebased = (cfg.window_base != '0) ? cfg.window_base + query_value : '0;
        if (is_query)
        begin
            if (is_abs)
            begin
                s1_next.kind = arsym_pkg::KIND_ABS;
                s1_next.off  = base_diff[31:0];
            end
            else if (is_raw)
            begin
                s1_next.kind = arsym_pkg::KIND_RAW;
                s1_next.off  = query_value[31:0];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && !is_query && !full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (adv)
            begin
                s1_reg <= s1_next;
            end
        end
    end

    // stage 2: fault proximity, raw reading first
    assign fault_on = s1_reg.query && (cfg.fault_address != '0);
    assign raw_chk  = check_near(s1_reg.value, cfg.fault_address);
    assign reb_chk  = check_near(s1_reg.rebased, cfg.fault_address);

    always_comb
    begin
        tok_next         = '0;
        tok_next.valid   = s1_reg.valid;
        tok_next.query   = s1_reg.query;
        tok_next.kind    = s1_reg.kind;
        tok_next.off     = s1_reg.off;
        tok_next.slot    = s1_reg.slot;
        tok_next.start   = s1_reg.start;
        tok_next.length  = s1_reg.length;
        tok_next.dropped = s1_reg.dropped;
        if (fault_on)
        begin
            if (raw_chk.eq)
            begin
                tok_next.hint    = arsym_pkg::HINT_EQUAL;
                tok_next.reading = arsym_pkg::READ_RAW;
            end
            else if (raw_chk.near)
            begin
                tok_next.hint     = arsym_pkg::HINT_NEAR;
                tok_next.reading  = arsym_pkg::READ_RAW;
                tok_next.distance = raw_chk.distance;
            end
            else if (reb_chk.eq)
            begin
                tok_next.hint    = arsym_pkg::HINT_EQUAL;
                tok_next.reading = arsym_pkg::READ_REBASED;
            end
            else if (reb_chk.near)
            begin
                tok_next.hint     = arsym_pkg::HINT_NEAR;
                tok_next.reading  = arsym_pkg::READ_REBASED;
                tok_next.distance = reb_chk.distance;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok   = tok_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/address_range_symbolizer.sv =====
// channel | direction | handshake           | payload
// config  | in        | psel/penable/pready | paddr, pwrite, pwdata, prdata
// item    | in        | in_valid/in_ready   | cmd, range_start, range_length, query_value
// result  | out       | out_valid/out_ready | reading_kind .. record_dropped
//
// one transfer per cycle in and out while the row is not held; an item passes
// two head stages, one stage per table cell and the output register
// each cell holds one range; appends and queries walk the cell row in order
// rst_n clears the range count, the config registers and all pipeline valids
// the row moves as one; it holds only when the result register is full,
// not taken, and the last cell holds an item
`default_nettype none

`include "address_range_symbolizer_defines.svh"

module address_range_symbolizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arsym_pkg::ADDR_W-1:0]     paddr,
    input  logic [arsym_pkg::DATA_W-1:0]     pwdata,
    output logic [arsym_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [31:0]                      range_start,
    input  logic [31:0]                      range_length,
    input  logic [63:0]                      query_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       reading_kind,
    output logic [31:0]                      window_offset,
    output logic                             range_hit,
    output logic [7:0]                       range_index,
    output logic [31:0]                      offset_in_range,
    output logic [1:0]                       fault_hint,
    output logic                             fault_reading,
    output logic [11:0]                      fault_distance,
    output logic                             record_dropped
);

    arsym_pkg::cfg_t   cfg_reg;
    logic              cfg_wr;
    logic [1:0]        reg_sel;
    arsym_pkg::token_t chain [0:arsym_pkg::TABLE_DEPTH];
    arsym_pkg::token_t tail;
    arsym_pkg::token_t out_reg;
    logic              out_load;
    logic              adv;
    arsym_pkg::cnt_t   count;
    logic              append_xfer;
    logic              hit_sane;
    logic              drop_bare;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = paddr[arsym_pkg::ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                arsym_pkg::REG_WINDOW_BASE:   cfg_reg.window_base   <= pwdata;
                arsym_pkg::REG_WINDOW_SIZE:   cfg_reg.window_size   <= pwdata[32:0];
                arsym_pkg::REG_FAULT_ADDRESS: cfg_reg.fault_address <= pwdata;
                default:                      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            arsym_pkg::REG_WINDOW_BASE:   prdata = cfg_reg.window_base;
            arsym_pkg::REG_WINDOW_SIZE:   prdata = {31'b0, cfg_reg.window_size};
            arsym_pkg::REG_FAULT_ADDRESS: prdata = cfg_reg.fault_address;
            default:                      prdata = '0;
        endcase
    end

    // row control
    assign tail     = chain[arsym_pkg::TABLE_DEPTH];
    assign out_load = !out_reg.valid || out_ready;
    assign adv      = out_load || !tail.valid;
    assign in_ready = adv;

    arsym_head u_head (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .cmd          (cmd),
        .range_start  (range_start),
        .range_length (range_length),
        .query_value  (query_value),
        .cfg          (cfg_reg),
        .tok          (chain[0]),
        .count        (count)
    );

    for (genvar g = 0; g < arsym_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        arsym_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (arsym_pkg::idx_t'(g)),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (out_load)
        begin
            out_reg <= tail;
        end
    end

    assign out_valid       = out_reg.valid;
    assign reading_kind    = out_reg.kind;
    assign window_offset   = out_reg.off;
    assign range_hit       = out_reg.hit;
    assign range_index     = 8'(out_reg.idx);
    assign offset_in_range = out_reg.rel;
    assign fault_hint      = out_reg.hint;
    assign fault_reading   = out_reg.reading;
    assign fault_distance  = out_reg.distance;
    assign record_dropped  = out_reg.dropped;

    assign append_xfer = in_valid && in_ready && (cmd == arsym_pkg::CMD_APPEND)
                         && (count < arsym_pkg::FULL_COUNT);
    assign hit_sane    = (reading_kind != arsym_pkg::KIND_NONE)
                         && (offset_in_range <= window_offset);
    assign drop_bare   = (reading_kind == arsym_pkg::KIND_NONE) && !range_hit
                         && (fault_hint == arsym_pkg::HINT_NONE);

    `ARSYM_ASSERT_ALWAYS(a_count_bound, count <= arsym_pkg::FULL_COUNT)
    `ARSYM_ASSERT_NEXT(a_count_step, append_xfer, count == $past(count) + 1'b1)
    `ARSYM_ASSERT_IMPLY(a_hit_in_window, out_valid && range_hit, hit_sane)
    `ARSYM_ASSERT_IMPLY(a_drop_is_bare, out_valid && record_dropped, drop_bare)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;

    import arsym_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int ROUNDS = 6;
    localparam int ROUND_ITEMS = 305;
    localparam int HOLD_MARK = 40;
    localparam int HOLD_CYCLES = 4000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] offset;
        logic        hit;
        logic [7:0]  index;
        logic [31:0] rel;
        logic [1:0]  hint;
        logic        reading;
        logic [11:0] distance;
        logic        dropped;
    } sym_result_t;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [63:0] data;
        logic        c;
        logic [31:0] s;
        logic [31:0] l;
        logic [63:0] v;
        bit          typed;
        sym_result_t exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic [31:0] range_start;
    logic [31:0] range_length;
    logic [63:0] query_value;
    logic out_valid;
    logic out_ready;
    logic [1:0] reading_kind;
    logic [31:0] window_offset;
    logic range_hit;
    logic [7:0] range_index;
    logic [31:0] offset_in_range;
    logic [1:0] fault_hint;
    logic fault_reading;
    logic [11:0] fault_distance;
    logic record_dropped;

    address_range_symbolizer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .range_start(range_start),
        .range_length(range_length),
        .query_value(query_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .reading_kind(reading_kind),
        .window_offset(window_offset),
        .range_hit(range_hit),
        .range_index(range_index),
        .offset_in_range(offset_in_range),
        .fault_hint(fault_hint),
        .fault_reading(fault_reading),
        .fault_distance(fault_distance),
        .record_dropped(record_dropped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [63:0] win_base;
    logic [32:0] win_size;
    logic [63:0] fault_target;
    logic [31:0] span_start [TABLE_DEPTH];
    logic [31:0] span_len [TABLE_DEPTH];
    int span_count;

    sym_result_t pending_lookups[$];
    int accepted_items;
    int results_seen;
    int mismatches;

    function automatic sym_result_t symbolize(input logic c, input logic [31:0] s,
                                              input logic [31:0] l, input logic [63:0] v);
        sym_result_t r;
        logic [63:0] delta;
        logic [63:0] reading [2];
        logic [32:0] span_end;
        int i;
        int j;
        r = '0;
        if (c == CMD_APPEND)
        begin
            if (span_count < TABLE_DEPTH)
            begin
                span_start[span_count] = s;
                span_len[span_count] = l;
                span_count++;
            end
            else
            begin
                r.dropped = 1'b1;
            end
            return r;
        end
        delta = v - win_base;
        if (win_base != 0 && v >= win_base && delta < 64'(win_size))
        begin
            r.kind = KIND_ABS;
            r.offset = delta[31:0];
        end
        else if (v != 0 && v < 64'(win_size))
        begin
            r.kind = KIND_RAW;
            r.offset = v[31:0];
        end
        if (r.kind != KIND_NONE)
        begin
            for (i = 0; i < span_count; i++)
            begin
                span_end = {1'b0, span_start[i]} + {1'b0, span_len[i]};
                if (span_start[i] <= r.offset && {1'b0, r.offset} < span_end)
                begin
                    r.hit = 1'b1;
                    r.index = 8'(i);
                    r.rel = r.offset - span_start[i];
                end
            end
        end
        if (fault_target != 0)
        begin
            reading[0] = v;
            reading[1] = (win_base != 0) ? win_base + v : 64'd0;
            for (j = 0; j < 2; j++)
            begin
                delta = fault_target - reading[j];
                if (r.hint == HINT_NONE && reading[j] != 0)
                begin
                    if (reading[j] == fault_target)
                    begin
                        r.hint = HINT_EQUAL;
                        r.reading = (j == 0) ? READ_RAW : READ_REBASED;
                    end
                    else if (fault_target > reading[j] && delta < 64'(NEAR_LIMIT))
                    begin
                        r.hint = HINT_NEAR;
                        r.reading = (j == 0) ? READ_RAW : READ_REBASED;
                        r.distance = delta[11:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic c, input logic [31:0] s,
                                           input logic [31:0] l, input logic [63:0] v,
                                           input bit typed, input sym_result_t exp);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.sel = REG_WINDOW_BASE;
        row.data = '0;
        row.c = c;
        row.s = s;
        row.l = l;
        row.v = v;
        row.typed = typed;
        row.exp = exp;
        return row;
    endfunction

    function automatic stim_row_t config_row(input logic [1:0] sel, input logic [63:0] data);
        stim_row_t row;
        row = item_row(CMD_APPEND, '0, '0, '0, 1'b0, '0);
        row.kind = ROW_CONFIG;
        row.sel = sel;
        row.data = data;
        return row;
    endfunction

    task automatic write_reg(input logic [1:0] sel, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 3'b000};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_WINDOW_BASE: win_base = data;
            REG_WINDOW_SIZE: win_size = data[32:0];
            REG_FAULT_ADDRESS: fault_target = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input logic c, input logic [31:0] s, input logic [31:0] l,
                             input logic [63:0] v, input bit typed, input sym_result_t exp,
                             input bit gapless);
        int gap;
        sym_result_t predicted;
        gap = gapless ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        range_start <= s;
        range_length <= l;
        query_value <= v;
        do @(posedge clk); while (!in_ready);
        predicted = symbolize(c, s, l, v);
        pending_lookups = {pending_lookups, (typed ? exp : predicted)};
        accepted_items++;
    endtask

    task automatic load_window(input int round_no);
        logic [63:0] b;
        logic [32:0] z;
        logic [63:0] f;
        case (round_no)
            0:
            begin
                b = {$urandom(), $urandom() & 32'hFFF0_0000};
                z = 33'h4_0000;
                f = b + 64'($urandom_range(0, 32'h4_0000));
            end
            1:
            begin
                b = 64'd0;
                z = 33'h1_0000_0000;
                f = 64'($urandom_range(1, 32'h4_0000));
            end
            2:
            begin
                b = 64'hFFFF_FFFF_FFFF_F000;
                z = 33'h1_0000_0000;
                f = 64'hFFFF_FFFF_FFFF_FFFF;
            end
            3:
            begin
                b = {$urandom(), $urandom()};
                z = {1'b0, $urandom()};
                f = {$urandom(), $urandom()};
            end
            4:
            begin
                b = 64'd1;
                z = 33'h8_0000;
                f = 64'd0;
            end
            default:
            begin
                b = 64'h0000_0000_1000_0000;
                z = 33'h2000_0000;
                f = 64'h0000_0000_1000_3000;
            end
        endcase
        settle();
        write_reg(REG_WINDOW_BASE, b);
        write_reg(REG_WINDOW_SIZE, {31'd0, z});
        write_reg(REG_FAULT_ADDRESS, f);
    endtask

    task automatic draw_item(input int round_no, output logic c, output logic [31:0] s,
                             output logic [31:0] l, output logic [63:0] v);
        int k;
        logic [31:0] off;
        s = $urandom();
        l = $urandom();
        v = {$urandom(), $urandom()};
        c = CMD_QUERY;
        if ($urandom_range(0, 99) < ((round_no < 3) ? 35 : 8))
        begin
            c = CMD_APPEND;
            case ($urandom_range(0, 9))
                0: ;
                1: l = 32'd0;
                2:
                begin
                    s = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
                    l = $urandom_range(32'h1_0000, 32'hFFFF_FFFF);
                end
                3, 4:
                begin
                    if (span_count > 0)
                    begin
                        k = $urandom_range(0, span_count - 1);
                        s = span_start[k] + (span_len[k] >> $urandom_range(1, 8));
                        l = $urandom_range(1, 32'h400);
                    end
                end
                default:
                begin
                    s = $urandom_range(0, 32'h3_FFFF);
                    l = $urandom_range(1, 32'h2000);
                end
            endcase
            return;
        end
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5:
            begin
                off = $urandom_range(0, 32'h3_FFFF);
                if (span_count > 0 && $urandom_range(0, 4) != 0)
                begin
                    k = $urandom_range(0, span_count - 1);
                    if (span_len[k] != 0)
                        off = span_start[k] + $urandom_range(0, span_len[k] - 1);
                end
                v = (win_base != 0 && $urandom_range(0, 1) == 1) ? win_base + 64'(off)
                                                                  : 64'(off);
            end
            6: v = fault_target - 64'($urandom_range(0, 4200));
            7: v = fault_target - win_base - 64'($urandom_range(0, 4200));
            8:
            begin
                case ($urandom_range(0, 6))
                    0: v = win_base - 64'd1;
                    1: v = win_base + 64'(win_size) - 64'd1;
                    2: v = win_base + 64'(win_size);
                    3: v = 64'(win_size) - 64'd1;
                    4: v = 64'(win_size);
                    5: v = 64'd0;
                    default: v = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t result %0d %s: expected %0h, actual %0h",
                     $time, results_seen, name, want, got);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        bit held;
        sym_result_t want;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && accepted_items >= HOLD_MARK)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = ((results_seen / 100) % 4 == 2) ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected transfer: expected none, actual kind %0h dropped %0b",
                         $time, reading_kind, record_dropped);
            end
            else
            begin
                want = pending_lookups.pop_front();
                compare_field("reading_kind", 64'(want.kind), 64'(reading_kind));
                compare_field("window_offset", 64'(want.offset), 64'(window_offset));
                compare_field("range_hit", 64'(want.hit), 64'(range_hit));
                compare_field("range_index", 64'(want.index), 64'(range_index));
                compare_field("offset_in_range", 64'(want.rel), 64'(offset_in_range));
                compare_field("fault_hint", 64'(want.hint), 64'(fault_hint));
                compare_field("fault_reading", 64'(want.reading), 64'(fault_reading));
                compare_field("fault_distance", 64'(want.distance), 64'(fault_distance));
                compare_field("record_dropped", 64'(want.dropped), 64'(record_dropped));
            end
            results_seen++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t plan[$];
        stim_row_t row;
        logic c;
        logic [31:0] s;
        logic [31:0] l;
        logic [63:0] v;
        int p;
        int n;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_APPEND;
        range_start <= '0;
        range_length <= '0;
        query_value <= '0;
        win_base = '0;
        win_size = '0;
        fault_target = '0;
        span_count = 0;
        accepted_items = 0;
        results_seen = 0;
        mismatches = 0;

        // reset state: no window, no fault, empty table
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'd0, 1'b1, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0)};
        plan = {plan, item_row(CMD_APPEND, 32'd0, 32'd0, 64'd0, 1'b1, '0)};
        plan = {plan, item_row(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b1, '0)};
        plan = {plan, item_row(CMD_APPEND, 32'h1000, 32'h100, 64'd0, 1'b1, '0)};
        plan = {plan, item_row(CMD_APPEND, 32'h1080, 32'h10, 64'd0, 1'b1, '0)};

        plan = {plan, config_row(REG_WINDOW_BASE, 64'h8000_0000_0000_0000)};
        plan = {plan, config_row(REG_WINDOW_SIZE, 64'h1_0000_0000)};
        plan = {plan, config_row(REG_FAULT_ADDRESS, 64'h8000_0000_0000_1010)};
        plan = {plan, config_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_1088, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h1000, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'hFFFF_FFFF, 1'b1,
            '{KIND_RAW, 32'hFFFF_FFFF, 1'b1, 8'd1, 32'd0, HINT_NONE, READ_RAW, 12'd0, 1'b0})};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'd0, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h8000_0001_0000_0000, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_1010, 1'b1,
            '{KIND_ABS, 32'h1010, 1'b1, 8'd2, 32'h10, HINT_EQUAL, READ_RAW, 12'd0, 1'b0})};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_0011, 1'b1,
            '{KIND_ABS, 32'h11, 1'b0, 8'd0, 32'd0, HINT_NEAR, READ_RAW, 12'hFFF, 1'b0})};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_0010, 1'b0, '0)};

        // window at the very top of the address space
        plan = {plan, config_row(REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_FFFF)};
        plan = {plan, config_row(REG_WINDOW_SIZE, 64'h10)};
        plan = {plan, config_row(REG_FAULT_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            '{KIND_ABS, 32'd0, 1'b0, 8'd0, 32'd0, HINT_EQUAL, READ_RAW, 12'd0, 1'b0})};
        plan = {plan, item_row(CMD_APPEND, 32'h5, 32'h4, 64'd0, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'hF, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h10, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h6, 1'b0, '0)};

        // no window, no fault, raw offsets only
        plan = {plan, config_row(REG_WINDOW_BASE, 64'd0)};
        plan = {plan, config_row(REG_WINDOW_SIZE, 64'h2000)};
        plan = {plan, config_row(REG_FAULT_ADDRESS, 64'd0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h1050, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h1085, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h1FFF, 1'b0, '0)};
        plan = {plan, item_row(CMD_APPEND, 32'h1000, 32'h1000, 64'd0, 1'b0, '0)};
        plan = {plan, item_row(CMD_QUERY, 32'd0, 32'd0, 64'h1085, 1'b0, '0)};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CONFIG)
            begin
                settle();
                write_reg(row.sel, row.data);
            end
            else
            begin
                send_item(row.c, row.s, row.l, row.v, row.typed, row.exp, 1'b0);
            end
        end

        for (p = 0; p < ROUNDS; p++)
        begin
            load_window(p);
            for (n = 0; n < ROUND_ITEMS; n++)
            begin
                draw_item(p, c, s, l, v);
                send_item(c, s, l, v, 1'b0, '0, ((n / 50) % 5 == 4));
            end
        end

        settle();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
